/* rtl/mrt_pkg.sv */
package mrt_pkg;

  // table geometry
  localparam int ENTRIES   = 32;
  localparam int PROC_BITS = 16;
  localparam int IDX_BITS  = $clog2(ENTRIES);
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int REG_BITS  = 17;

  // request codes
  typedef enum logic [1:0] {
    FUNC_LOOKUP  = 2'd0,
    FUNC_ADD     = 2'd1,
    FUNC_DELETE  = 2'd2,
    FUNC_DEL_ALL = 2'd3
  } func_t;

  // result codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  // register indexes
  localparam logic REG_LOCAL_NODE   = 1'b0;
  localparam logic REG_DEFAULT_PROC = 1'b1;

  // target value when nothing is found
  localparam logic signed [REG_BITS-1:0] TARGET_NONE = '1;

  // write request into the entry store
  typedef struct packed {
    logic                 en;
    logic [IDX_BITS-1:0]  addr;
    logic [PROC_BITS-1:0] key;
    logic [PROC_BITS-1:0] tgt;
  } store_wr_t;

endpackage

/* rtl/message_route_table.sv */
// message route table: maps a destination process number to a forwarding process
//
// input channel (in_valid / in_stall) carries one request item: lookup, add or
// update, delete one key, or delete all. every request gives exactly one result
// item on the output channel (out_valid / out_stall). in_stall is high from the
// accepted item until its result is loaded into the output register. the user
// writes node number and default process over apb only while idle (unchecked).
//
// lookups, adds and deletes scan all ENTRIES slots through one read port of the
// entry store and a single key comparator, one slot per cycle. a finish state
// then loads the result into the output register and returns to idle; only there
// is the next item taken. a lookup for another node and delete-all skip the scan
// and go straight to the finish state, where the result is loaded the same way.
// when the receiver stalls, the result holds in the output register and the
// block waits before loading the next one, keeping in_stall high.
// reset clears all valid bits, sets both registers to -1 and empties the
// output register; the block is ready in the first cycle after reset.
module message_route_table (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic [15:0]                       in_dst_node,
  input  logic [15:0]                       in_dst_proc,
  input  logic [15:0]                       in_new_target,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [16:0]                out_target,
  output logic                              out_via_default,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import mrt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic signed [REG_BITS-1:0]  local_node_r, default_proc_r;
  logic [ENTRIES-1:0]          valid_r, valid_nxt;
  logic [CNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic                        cmp_vld_r;
  logic [IDX_BITS-1:0]         cmp_idx_r;
  logic                        hit_r, hit_nxt;
  logic [IDX_BITS-1:0]         hit_slot_r, hit_slot_nxt;
  logic [PROC_BITS-1:0]        hit_tgt_r, hit_tgt_nxt;
  logic                        free_r, free_nxt;
  logic [IDX_BITS-1:0]         free_slot_r, free_slot_nxt;
  func_t                       func_r;
  logic [PROC_BITS-1:0]        key_r, tgt_r;
  logic                        dflt_r;
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic signed [REG_BITS-1:0]  out_target_r;
  logic                        out_via_r;

  logic                        in_acc, cfg_wr, take_default, issue, fin_go;
  logic                        rd_key_hit;
  logic [PROC_BITS-1:0]        rd_key, rd_tgt;
  store_wr_t                   wr;
  status_t                     res_status;
  logic signed [REG_BITS-1:0]  res_target;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign take_default = (func_t'(in_func) == FUNC_LOOKUP) && (in_dst_node != '0) &&
                        (local_node_r != $signed({1'b0, in_dst_node}));
  assign issue    = (state_r == ST_SCAN) && (cnt_r < CNT_BITS'(ENTRIES));
  assign fin_go   = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_LOCAL_NODE) ? 32'(local_node_r) : 32'(default_proc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_node_r   <= TARGET_NONE;
      default_proc_r <= TARGET_NONE;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LOCAL_NODE) begin
        local_node_r <= $signed(pwdata[REG_BITS-1:0]);
      end else begin
        default_proc_r <= $signed(pwdata[REG_BITS-1:0]);
      end
    end
  end

  // entry store, scanned through its read port
  mrt_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (issue),
    .rd_addr (cnt_r[IDX_BITS-1:0]),
    .rd_key  (rd_key),
    .rd_tgt  (rd_tgt)
  );

  // shared key comparator
  assign rd_key_hit = cmp_vld_r && valid_r[cmp_idx_r] && (rd_key == key_r);

  // result and table update for the finishing item; delete-all clears at acceptance
  always_comb begin
    res_status = STAT_OK;
    res_target = TARGET_NONE;
    wr         = '0;
    wr.key     = key_r;
    wr.tgt     = tgt_r;
    valid_nxt  = valid_r;
    case (func_r)
      FUNC_LOOKUP: begin
        if (dflt_r) begin
          res_target = default_proc_r;
        end else if (hit_r) begin
          res_target = $signed({1'b0, hit_tgt_r});
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      FUNC_ADD: begin
        if (hit_r || free_r) begin
          wr.en   = fin_go;
          wr.addr = hit_r ? hit_slot_r : free_slot_r;
          if (fin_go) begin
            valid_nxt[wr.addr] = 1'b1;
          end
        end else begin
          res_status = STAT_FULL;
        end
      end
      FUNC_DELETE: begin
        if (hit_r && fin_go) begin
          valid_nxt[hit_slot_r] = 1'b0;
        end
      end
      default: ;
    endcase
    // delete-all clears every slot at acceptance
    if (in_acc && func_t'(in_func) == FUNC_DEL_ALL) begin
      valid_nxt = '0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    hit_tgt_nxt   = hit_tgt_r;
    free_nxt      = free_r;
    free_slot_nxt = free_slot_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          if (take_default || func_t'(in_func) == FUNC_DEL_ALL) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + CNT_BITS'(1);
        end
        if (rd_key_hit && !hit_r) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = cmp_idx_r;
          hit_tgt_nxt  = rd_tgt;
        end
        if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_r) begin
          free_nxt      = 1'b1;
          free_slot_nxt = cmp_idx_r;
        end
        if (!issue && cmp_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= issue;
      hit_r     <= hit_nxt;
      free_r    <= free_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r   <= cnt_r[IDX_BITS-1:0];
    hit_slot_r  <= hit_slot_nxt;
    hit_tgt_r   <= hit_tgt_nxt;
    free_slot_r <= free_slot_nxt;
    if (in_acc) begin
      func_r <= func_t'(in_func);
      key_r  <= in_dst_proc;
      tgt_r  <= in_new_target;
      dflt_r <= take_default;
    end
    if (fin_go) begin
      out_status_r <= res_status;
      out_target_r <= res_target;
      out_via_r    <= (func_r == FUNC_LOOKUP) && dflt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_target      = out_target_r;
  assign out_via_default = out_via_r;

endmodule

/* rtl/mrt_store.sv */
module mrt_store (
  input  logic                          clk,
  input  mrt_pkg::store_wr_t            wr,
  input  logic                          rd_en,
  input  logic [mrt_pkg::IDX_BITS-1:0]  rd_addr,
  output logic [mrt_pkg::PROC_BITS-1:0] rd_key,
  output logic [mrt_pkg::PROC_BITS-1:0] rd_tgt
);
  import mrt_pkg::*;

  logic [PROC_BITS-1:0] key_mem [ENTRIES];
  logic [PROC_BITS-1:0] tgt_mem [ENTRIES];

  // one write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr] <= wr.key;
      tgt_mem[wr.addr] <= wr.tgt;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_tgt <= tgt_mem[rd_addr];
    end
  end

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mrt_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = ENTRIES + 8;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 128;
  localparam int POOL_MAX       = 48;
  localparam int FILL_ITEMS     = 36;
  localparam logic signed [REG_BITS-1:0] NONE = TARGET_NONE;

  typedef struct packed {
    func_t       func;
    logic [15:0] node;
    logic [15:0] proc;
    logic [15:0] tgt;
  } route_req_t;

  typedef struct packed {
    status_t                    status;
    logic signed [REG_BITS-1:0] target;
    logic                       via;
  } route_res_t;

  typedef struct packed {
    route_req_t req;
    logic       typed;
    route_res_t res;
  } route_row_t;

  // dut ports
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_func = '0;
  logic [15:0]                in_dst_node = '0;
  logic [15:0]                in_dst_proc = '0;
  logic [15:0]                in_new_target = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_status;
  logic signed [16:0]         out_target;
  logic                       out_via_default;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  // shadow of the route table and registers
  logic [PROC_BITS-1:0]       rt_key    [ENTRIES];
  logic [PROC_BITS-1:0]       rt_target [ENTRIES];
  logic                       rt_used   [ENTRIES];
  logic signed [REG_BITS-1:0] node_reg = NONE;
  logic signed [REG_BITS-1:0] default_reg = NONE;

  route_res_t                 pending_routes [$];
  route_res_t                 head;
  logic [15:0]                key_pool [POOL_MAX];

  // traffic shaping shared between sender and receiver
  logic                       steady = 1'b0;
  int                         hold_asked = 0;
  int                         hold_served = 0;
  int                         hold_left = 0;
  int                         idle_cycles = 0;

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_hit = 0;
  int n_miss = 0;
  int n_default = 0;
  int n_full = 0;
  int n_flush = 0;

  // directed items, reset register values throughout
  route_row_t dir_rows [23] = '{
    '{'{FUNC_LOOKUP,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{STAT_NOT_FOUND, NONE, 1'b0}},
    '{'{FUNC_LOOKUP,  16'hFFFF, 16'h1234, 16'h0000}, 1'b1, '{STAT_OK, NONE, 1'b1}},
    '{'{FUNC_LOOKUP,  16'h0001, 16'h0000, 16'hFFFF}, 1'b1, '{STAT_OK, NONE, 1'b1}},
    '{'{FUNC_DELETE,  16'hFFFF, 16'h5555, 16'hFFFF}, 1'b1, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_ADD,     16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_ADD,     16'h0000, 16'hFFFF, 16'h0000}, 1'b1, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_LOOKUP,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{STAT_OK, 17'sh0FFFF, 1'b0}},
    '{'{FUNC_LOOKUP,  16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, '{STAT_OK, 17'sh00000, 1'b0}},
    '{'{FUNC_ADD,     16'h1234, 16'h0000, 16'h1234}, 1'b1, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_LOOKUP,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{STAT_OK, 17'sh01234, 1'b0}},
    '{'{FUNC_ADD,     16'h0000, 16'hAAAA, 16'h5555}, 1'b1, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_ADD,     16'h0000, 16'h5555, 16'hAAAA}, 1'b1, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_LOOKUP,  16'h0000, 16'hAAAA, 16'h0000}, 1'b0, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_DELETE,  16'h0000, 16'hFFFF, 16'h0000}, 1'b1, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_LOOKUP,  16'h0000, 16'hFFFF, 16'h0000}, 1'b1, '{STAT_NOT_FOUND, NONE, 1'b0}},
    '{'{FUNC_ADD,     16'h0000, 16'hFFFF, 16'h8001}, 1'b0, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_LOOKUP,  16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_DELETE,  16'h0000, 16'h1234, 16'h0000}, 1'b1, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_DEL_ALL, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_LOOKUP,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{STAT_NOT_FOUND, NONE, 1'b0}},
    '{'{FUNC_LOOKUP,  16'h0000, 16'h5555, 16'h0000}, 1'b1, '{STAT_NOT_FOUND, NONE, 1'b0}},
    '{'{FUNC_ADD,     16'h8000, 16'h0001, 16'h7FFF}, 1'b0, '{STAT_OK, NONE, 1'b0}},
    '{'{FUNC_LOOKUP,  16'h0000, 16'h0001, 16'h0000}, 1'b0, '{STAT_OK, NONE, 1'b0}}
  };

  message_route_table u_dut (.*);

  always #10 clk = ~clk;

  // slot holding a key, -1 when absent
  function automatic int find_route(input logic [PROC_BITS-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (rt_used[i] && rt_key[i] == key) return i;
    return -1;
  endfunction

  // applies one request to the shadow table and returns its result
  function automatic route_res_t route_predict(input route_req_t r);
    route_res_t res;
    int         slot;
    res = '{STAT_OK, NONE, 1'b0};
    case (r.func)
      FUNC_LOOKUP: begin
        // another node goes straight to the default process
        if (r.node != '0 && node_reg != {1'b0, r.node}) begin
          res.target = default_reg;
          res.via    = 1'b1;
        end else begin
          slot = find_route(r.proc);
          if (slot >= 0) res.target = {1'b0, rt_target[slot]};
          else res.status = STAT_NOT_FOUND;
        end
      end
      FUNC_ADD: begin
        slot = find_route(r.proc);
        // new key takes the lowest free slot
        if (slot < 0)
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!rt_used[i]) slot = i;
        if (slot >= 0) begin
          rt_key[slot]    = r.proc;
          rt_target[slot] = r.tgt;
          rt_used[slot]   = 1'b1;
        end else begin
          res.status = STAT_FULL;
        end
      end
      FUNC_DELETE: begin
        slot = find_route(r.proc);
        if (slot >= 0) rt_used[slot] = 1'b0;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) rt_used[i] = 1'b0;
      end
    endcase
    return res;
  endfunction

  // random request over the current key pool, unused fields left random
  function automatic route_req_t random_req(input int psize);
    route_req_t r;
    int         pick;
    r.node = 16'($urandom);
    r.proc = ($urandom_range(9) == 0) ? 16'($urandom) : key_pool[$urandom_range(psize - 1)];
    r.tgt  = 16'($urandom);
    pick   = $urandom_range(99);
    if (pick < 40) begin
      r.func = FUNC_LOOKUP;
      pick   = $urandom_range(9);
      if (pick < 4) r.node = '0;
      else if (pick < 7) r.node = node_reg[15:0];
    end else if (pick < 75) begin
      r.func = FUNC_ADD;
    end else if (pick < 98) begin
      r.func = FUNC_DELETE;
    end else begin
      r.func = FUNC_DEL_ALL;
    end
    return r;
  endfunction

  // offer one item, predict it once taken
  task automatic offer_item(input route_req_t r, input logic typed, input route_res_t want);
    route_res_t calc;
    if (!steady && $urandom_range(99) < 8) begin
      in_valid      <= 1'b0;
      in_func       <= 2'($urandom);
      in_dst_node   <= 16'($urandom);
      in_dst_proc   <= 16'($urandom);
      in_new_target <= 16'($urandom);
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= r.func;
    in_dst_node   <= r.node;
    in_dst_proc   <= r.proc;
    in_new_target <= r.tgt;
    do @(posedge clk); while (in_stall);
    calc = route_predict(r);
    pending_routes.push_back(typed ? want : calc);
    n_sent++;
    if (r.func == FUNC_LOOKUP) begin
      if (calc.via) n_default++;
      else if (calc.status == STAT_OK) n_hit++;
      else n_miss++;
    end
    if (calc.status == STAT_FULL) n_full++;
    if (r.func == FUNC_DEL_ALL) n_flush++;
  endtask

  // stop offering until every result is back, then let the block settle
  task automatic drain_routes(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_routes.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // apb write: setup then access
  task automatic write_reg(input logic idx, input logic signed [REG_BITS-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(32 - REG_BITS){v[REG_BITS-1]}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_LOCAL_NODE) node_reg = v;
    else default_reg = v;
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    route_req_t                 r;
    int                         psize;
    logic [15:0]                base;
    logic signed [REG_BITS-1:0] lval;
    logic signed [REG_BITS-1:0] dval;
    for (int i = 0; i < ENTRIES; i++) rt_used[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) offer_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < PHASES; p++) begin
      drain_routes(SETTLE_CYCLES);
      case (p)
        0: begin lval = 17'sd0;     dval = 17'sd0;     end
        1: begin lval = 17'sd65535; dval = 17'sd65535; end
        2: begin lval = NONE;       dval = 17'sd65535; end
        3: begin lval = 17'($urandom_range(1, 255)); dval = NONE; end
        4: begin lval = 17'sd65535; dval = 17'sd0;     end
        default: begin
          lval = ($urandom_range(3) == 0) ? NONE : 17'($urandom_range(65535));
          dval = ($urandom_range(3) == 0) ? NONE : 17'($urandom_range(65535));
        end
      endcase
      write_reg(REG_LOCAL_NODE, lval);
      write_reg(REG_DEFAULT_PROC, dval);

      // key pool: large pools start by filling the table past full
      case (p % 4)
        0:       psize = 40;
        1:       psize = 12;
        2:       psize = 4;
        default: psize = POOL_MAX;
      endcase
      base = 16'($urandom);
      for (int k = 0; k < POOL_MAX; k++) key_pool[k] = base + 16'(k * 7);
      steady = (p == 2);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 20) hold_asked <= hold_asked + 1;
        if (n == 64) drain_routes(0);
        r = random_req(psize);
        if (psize >= 40 && n < FILL_ITEMS) begin
          r.func = FUNC_ADD;
          r.proc = key_pool[n];
        end
        offer_item(r, 1'b0, '{STAT_OK, NONE, 1'b0});
      end
    end

    drain_routes(SETTLE_CYCLES);
    $display("covered %0d items over %0d register settings, %0d results checked",
             n_sent, PHASES + 1, n_checked);
    $display("lookups: %0d hits, %0d misses, %0d default; %0d adds refused full, %0d flushes",
             n_hit, n_miss, n_default, n_full, n_flush);
    if (errors == 0) begin
      $display("message_route_table verification clean");
    end else begin
      $display("message_route_table verification failed");
    end
    $finish;
  end

  // result checking and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_routes.size() == 0) begin
        $display("[%0t] result with nothing pending: status %0d target %0d via %0b",
                 $time, out_status, out_target, out_via_default);
        errors++;
      end else begin
        head = pending_routes.pop_front();
        n_checked++;
        if (out_status !== head.status) begin
          $display("[%0t] status: expected %0d, actual %0d", $time, head.status, out_status);
          errors++;
        end
        if (out_target !== head.target) begin
          $display("[%0t] target: expected %0d, actual %0d", $time, head.target, out_target);
          errors++;
        end
        if (out_via_default !== head.via) begin
          $display("[%0t] via_default: expected %0b, actual %0b",
                   $time, head.via, out_via_default);
          errors++;
        end
      end
    end

    // long hold-off on request, otherwise sparse random stalls except in the steady phase
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 8);
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, idle_cycles);
      $display("message_route_table verification failed");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/mrt_pkg.sv
rtl/mrt_store.sv
rtl/message_route_table.sv
bench/testbench.sv
